// ----- design/lsvf_pkg.sv -----
package lsvf_pkg;

  // Depth of the vote history
  localparam int unsigned MaxWindow = 8;

  // Widths of configuration registers, vote counts and stream words
  localparam int unsigned CfgW   = 4;
  localparam int unsigned CntW   = $clog2(MaxWindow + 1);
  localparam int unsigned CmpW   = (CntW > CfgW) ? CntW : CfgW;
  localparam int unsigned VoteW  = 2;
  localparam int unsigned TdataW = 8;

  // Register reset values
  localparam logic [CfgW-1:0] WindowLenRst     = CfgW'(5);
  localparam logic [CfgW-1:0] MajorityVotesRst = CfgW'(3);
  localparam logic [CfgW-1:0] HoldVotesRst     = CfgW'(2);

  typedef enum logic [VoteW-1:0] {
    LightUnknown = 2'd0,
    LightRed     = 2'd1,
    LightGreen   = 2'd2,
    LightOther   = 2'd3
  } light_e;

  typedef enum logic [1:0] {
    CfgWindowLen     = 2'd0,
    CfgMajorityVotes = 2'd1,
    CfgHoldVotes     = 2'd2
  } cfg_idx_e;

  // Colour tallies over the current window
  typedef struct packed {
    logic [CntW-1:0] red;
    logic [CntW-1:0] green;
  } vote_cnt_t;

endpackage

// ----- design/lsvf_window.sv -----
module lsvf_window import lsvf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [VoteW-1:0] vote_i,
  input  logic [CfgW-1:0]  window_len_i,
  output vote_cnt_t        cnt_o
);

  logic [VoteW-1:0] hist_q [MaxWindow];
  logic [VoteW-1:0] hist_d [MaxWindow];
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CmpW-1:0]  win_eff;

  // Shift the newest vote in at the head
  always_comb begin
    hist_d[0] = vote_i;
    for (int i = 1; i < MaxWindow; i++) begin
      hist_d[i] = hist_q[i-1];
    end
  end

  // Count votes since reset, saturating at the history depth
  assign fill_d = (fill_q < CntW'(MaxWindow)) ? fill_q + CntW'(1) : fill_q;

  // Clamp the window length to the legal range and to the votes held
  always_comb begin
    win_eff = CmpW'(window_len_i);
    if (win_eff == '0) begin
      win_eff = CmpW'(1);
    end
    if (win_eff > CmpW'(MaxWindow)) begin
      win_eff = CmpW'(MaxWindow);
    end
    if (win_eff > CmpW'(fill_d)) begin
      win_eff = CmpW'(fill_d);
    end
  end

  // Tally each colour over the newest entries
  always_comb begin
    cnt_o = '0;
    for (int i = 0; i < MaxWindow; i++) begin
      if (CmpW'(i) < win_eff) begin
        if (hist_d[i] == LightRed) begin
          cnt_o.red = cnt_o.red + CntW'(1);
        end else if (hist_d[i] == LightGreen) begin
          cnt_o.green = cnt_o.green + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int i = 0; i < MaxWindow; i++) begin
        hist_q[i] <= LightUnknown;
      end
    end else if (shift_i) begin
      fill_q <= fill_d;
      for (int i = 0; i < MaxWindow; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

  fill_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MaxWindow))
    else $error("fill count beyond history depth");

endmodule

// ----- design/lsvf_decide.sv -----
module lsvf_decide import lsvf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            update_i,
  input  vote_cnt_t       cnt_i,
  input  logic [CfgW-1:0] majority_votes_i,
  input  logic [CfgW-1:0] hold_votes_i,
  output light_e          stable_d_o
);

  light_e          stable_q, stable_d;
  logic [CmpW-1:0] red, green, held;

  assign red   = CmpW'(cnt_i.red);
  assign green = CmpW'(cnt_i.green);

  // Switch on a majority with a strict lead, else hold or drop to unknown
  always_comb begin
    stable_d = stable_q;
    case (stable_q)
      LightRed:   held = red;
      LightGreen: held = green;
      default:    held = '0;
    endcase
    if (red >= CmpW'(majority_votes_i) && red > green) begin
      stable_d = LightRed;
    end else if (green >= CmpW'(majority_votes_i) && green > red) begin
      stable_d = LightGreen;
    end else if (held < CmpW'(hold_votes_i)) begin
      stable_d = LightUnknown;
    end
  end

  assign stable_d_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= LightUnknown;
    end else if (update_i) begin
      stable_q <= stable_d;
    end
  end

  no_other_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stable_q != LightOther)
    else $error("stable colour holds the other class");

endmodule

// ----- design/light_state_vote_filter.sv -----
// Channel   | Direction | Word
// s_axis    | in        | tdata[1:0] light_class, tdata[7:2] unused
// m_axis    | out       | tdata[1:0] stable_state, tdata[7:2] zero
// cfg       | in        | cfg_idx_i 0 window_len, 1 majority_votes, 2 hold_votes
//
// From input word to result word: input register, then one pass through the
// history shift, tally and decision into the result register. One word per
// cycle is sustained while m_axis_tready is high; history and colour update
// in one pass. Reset clears the history, fill count and stable colour. A
// stalled result holds the result register and, one word later, the input.
module light_state_vote_filter import lsvf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,  // [1:0] light_class
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,  // [1:0] stable_state
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  logic             in_valid_q;
  logic [VoteW-1:0] in_vote_q;
  logic             out_valid_q;
  light_e           out_state_q;
  logic             advance;
  logic [CfgW-1:0]  window_len_q, majority_votes_q, hold_votes_q;
  vote_cnt_t        cnt;
  light_e           stable_d;

  // Move a word on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q     <= WindowLenRst;
      majority_votes_q <= MajorityVotesRst;
      hold_votes_q     <= HoldVotesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgWindowLen:     window_len_q     <= cfg_data_i;
        CfgMajorityVotes: majority_votes_q <= cfg_data_i;
        CfgHoldVotes:     hold_votes_q     <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_vote_q <= s_axis_tdata[VoteW-1:0];
    end
  end

  lsvf_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (advance),
    .vote_i       (in_vote_q),
    .window_len_i (window_len_q),
    .cnt_o        (cnt)
  );

  lsvf_decide u_decide (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .update_i         (advance),
    .cnt_i            (cnt),
    .majority_votes_i (majority_votes_q),
    .hold_votes_i     (hold_votes_q),
    .stable_d_o       (stable_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_state_q <= stable_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TdataW-VoteW){1'b0}}, out_state_q};

  advance_fills_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register empty after a word moved on");

  held_input_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_vote_q))
    else $error("input register lost a stalled word");

  legal_result_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_state_q != LightOther)
    else $error("result carries the other class");

endmodule
